[rtl/core/tthp_pkg.sv]
// Shared constants, types and helpers for the top-three selection block.
`default_nettype none

package tthp_pkg;

  localparam int unsigned MAX_DIM     = 128;
  localparam int unsigned SLOT_COUNT  = 3;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned RANK_W      = 2;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [0:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [0:0] REG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   column;
  } slot_t;

  typedef struct packed {
    slot_t [SLOT_COUNT-1:0] slot;
    logic  [SLOT_COUNT-1:0] valid;
  } snapshot_t;

  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] columns;
  } dims_t;

  function automatic logic [CNT_W-1:0] effective_count(input logic [CNT_W-1:0] c);
    if (c == '0) begin
      return CNT_W'(1);
    end
    if (c > CNT_W'(MAX_DIM)) begin
      return CNT_W'(MAX_DIM);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tthp_front.sv]
// Front end: accepts elements, tracks position and keeps the running top three.
`default_nettype none

module tthp_front
  import tthp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dims_t              dims_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [VALUE_W-1:0] element_value_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output snapshot_t               push_data_o
);

  slot_t [SLOT_COUNT-1:0] slot_q, slot_d;
  logic  [SLOT_COUNT-1:0] valid_q, valid_d;
  logic  [POS_W-1:0]      row_q, row_d;
  logic  [POS_W-1:0]      col_q, col_d;

  logic [CNT_W-1:0]      rows_eff;
  logic [CNT_W-1:0]      cols_eff;
  logic                  col_wrap;
  logic                  row_wrap;
  logic                  last;
  logic                  accept;
  logic [SLOT_COUNT-1:0] ins;
  logic [SLOT_COUNT-1:0] above;
  slot_t                 new_slot;

  assign rows_eff = effective_count(dims_i.rows);
  assign cols_eff = effective_count(dims_i.columns);
  assign col_wrap = ({1'b0, col_q} + CNT_W'(1)) >= cols_eff;
  assign row_wrap = ({1'b0, row_q} + CNT_W'(1)) >= rows_eff;
  assign last     = col_wrap && row_wrap;

  assign in_ready_o   = push_ready_i || !last;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = in_valid_i && last;

  assign new_slot = '{value: element_value_i, row: row_q, column: col_q};

  always_comb begin
    for (int k = 0; k < SLOT_COUNT; k++) begin
      ins[k] = !valid_q[k] || (element_value_i > slot_q[k].value);
    end
    above[0] = 1'b0;
    for (int k = 1; k < SLOT_COUNT; k++) begin
      above[k] = above[k-1] || ins[k-1];
    end
  end

  always_comb begin
    slot_d  = slot_q;
    valid_d = valid_q;
    if (ins[0]) begin
      slot_d[0]  = new_slot;
      valid_d[0] = 1'b1;
    end
    for (int k = 1; k < SLOT_COUNT; k++) begin
      if (above[k]) begin
        slot_d[k]  = slot_q[k-1];
        valid_d[k] = valid_q[k-1];
      end else if (ins[k]) begin
        slot_d[k]  = new_slot;
        valid_d[k] = 1'b1;
      end
    end
  end

  assign push_data_o = '{slot: slot_d, valid: valid_d};

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (col_wrap) begin
      col_d = '0;
      row_d = row_wrap ? '0 : row_q + POS_W'(1);
    end else begin
      col_d = col_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else if (accept) begin
      valid_q <= last ? '0 : valid_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= slot_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tthp_queue.sv]
// Short queue of finished top-three snapshots between front and back.
`default_nettype none

module tthp_queue
  import tthp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire snapshot_t push_data_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output snapshot_t      pop_data_o
);

  snapshot_t [QUEUE_DEPTH-1:0] mem_q;
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              push;
  logic              pop;

  assign push_ready_o = fill_q != FILL_W'(QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tthp_back.sv]
// Back end: walks one snapshot and emits its filled slots, largest first.
`default_nettype none

module tthp_back
  import tthp_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  output logic               head_pop_o,
  input  wire snapshot_t     head_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [RANK_W-1:0]  rank_o,
  output logic [VALUE_W-1:0] found_value_o,
  output logic [POS_W-1:0]   found_row_o,
  output logic [POS_W-1:0]   found_column_o,
  output logic               run_end_o
);

  logic [RANK_W-1:0]  rank_q;
  logic               out_valid_q;
  logic [RANK_W-1:0]  rank_out_q;
  logic [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]   row_q;
  logic [POS_W-1:0]   column_q;
  logic               run_end_q;
  logic               load;
  logic               next_filled;
  logic               is_final;

  assign load        = head_valid_i && (!out_valid_q || out_ready_i);
  assign next_filled = (rank_q == RANK_W'(SLOT_COUNT - 1)) ? 1'b0
                                                           : head_i.valid[rank_q + RANK_W'(1)];
  assign is_final    = !next_filled;
  assign head_pop_o  = load && is_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        rank_q      <= is_final ? '0 : rank_q + RANK_W'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rank_out_q <= rank_q;
      value_q    <= head_i.slot[rank_q].value;
      row_q      <= head_i.slot[rank_q].row;
      column_q   <= head_i.slot[rank_q].column;
      run_end_q  <= is_final;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rank_o         = rank_out_q;
  assign found_value_o  = value_q;
  assign found_row_o    = row_q;
  assign found_column_o = column_q;
  assign run_end_o      = run_end_q;

endmodule

`default_nettype wire

[rtl/core/top_three_with_position.sv]
// Top level of the streaming top-three selector with row and column tracking.
// Matrix elements enter one per clock in row-major order; the block counts row
// and column against the row_count (address 0) and column_count (address 4)
// registers, where 0 acts as 1 and values above 128 act as 128. It keeps the
// three largest values with their positions, the earlier element winning a
// tie. The last element of a matrix hands its snapshot to a two-entry queue,
// and the output side emits one to three results, largest first, at one per
// cycle while out_ready_i is high, with run_end on the last. Input takes one
// item per cycle; it stalls only on a matrix's last element while the snapshot
// queue is full, which happens only when the output side holds off, since a
// matrix never gives more results than it has elements. Change the size
// registers only while the block is idle.
`default_nettype none

module top_three_with_position
  import tthp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [VALUE_W-1:0] element_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [RANK_W-1:0]       rank_o,
  output logic [VALUE_W-1:0]      found_value_o,
  output logic [POS_W-1:0]        found_row_o,
  output logic [POS_W-1:0]        found_column_o,
  output logic                    run_end_o
);

  logic [CNT_W-1:0] row_count_q;
  logic [CNT_W-1:0] column_count_q;
  logic             cfg_write;
  logic [0:0]       reg_index;
  dims_t            dims;

  logic      push_valid;
  logic      push_ready;
  snapshot_t push_data;
  logic      head_valid;
  logic      head_pop;
  snapshot_t head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[2:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CNT_W'(1);
      column_count_q <= CNT_W'(1);
    end else if (cfg_write) begin
      case (reg_index)
        REG_ROW_COUNT:    row_count_q    <= pwdata[CNT_W-1:0];
        REG_COLUMN_COUNT: column_count_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ROW_COUNT:    prdata = DATA_W'(row_count_q);
      REG_COLUMN_COUNT: prdata = DATA_W'(column_count_q);
      default:          prdata = '0;
    endcase
  end

  assign dims = '{rows: row_count_q, columns: column_count_q};

  tthp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dims_i          (dims),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_data_o     (push_data)
  );

  tthp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_pop),
    .pop_data_o   (head)
  );

  tthp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_pop_o     (head_pop),
    .head_i         (head),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rank_o         (rank_o),
    .found_value_o  (found_value_o),
    .found_row_o    (found_row_o),
    .found_column_o (found_column_o),
    .run_end_o      (run_end_o)
  );

endmodule

`default_nettype wire
